@@ hw/rtl/rvdec_pkg.sv @@
// Shared codes, field constants and the decode result type for the RV32I subset decoder.
package rvdec_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned KIND_W = 5;
    localparam int unsigned FMT_W  = 3;
    localparam int unsigned REG_W  = 5;

    // instruction kinds
    localparam logic [KIND_W-1:0] K_LW    = 5'd0;
    localparam logic [KIND_W-1:0] K_SW    = 5'd1;
    localparam logic [KIND_W-1:0] K_LUI   = 5'd2;
    localparam logic [KIND_W-1:0] K_AUIPC = 5'd3;
    localparam logic [KIND_W-1:0] K_ADD   = 5'd4;
    localparam logic [KIND_W-1:0] K_SUB   = 5'd5;
    localparam logic [KIND_W-1:0] K_SLL   = 5'd6;
    localparam logic [KIND_W-1:0] K_SRL   = 5'd7;
    localparam logic [KIND_W-1:0] K_SRA   = 5'd8;
    localparam logic [KIND_W-1:0] K_ADDI  = 5'd9;
    localparam logic [KIND_W-1:0] K_SLLI  = 5'd10;
    localparam logic [KIND_W-1:0] K_SRLI  = 5'd11;
    localparam logic [KIND_W-1:0] K_SRAI  = 5'd12;
    localparam logic [KIND_W-1:0] K_SLTIU = 5'd13;
    localparam logic [KIND_W-1:0] K_JALR  = 5'd14;
    localparam logic [KIND_W-1:0] K_JAL   = 5'd15;
    localparam logic [KIND_W-1:0] K_BEQ   = 5'd16;
    localparam logic [KIND_W-1:0] K_BNE   = 5'd17;
    localparam logic [KIND_W-1:0] K_BLT   = 5'd18;
    localparam logic [KIND_W-1:0] K_BGE   = 5'd19;
    localparam logic [KIND_W-1:0] K_BLTU  = 5'd20;
    localparam logic [KIND_W-1:0] K_BGEU  = 5'd21;
    localparam logic [KIND_W-1:0] K_TRAP  = 5'd22;
    localparam logic [KIND_W-1:0] K_INV   = 5'd23;

    // formats
    localparam logic [FMT_W-1:0] F_I    = 3'd0;
    localparam logic [FMT_W-1:0] F_R    = 3'd1;
    localparam logic [FMT_W-1:0] F_S    = 3'd2;
    localparam logic [FMT_W-1:0] F_B    = 3'd3;
    localparam logic [FMT_W-1:0] F_U    = 3'd4;
    localparam logic [FMT_W-1:0] F_NONE = 3'd5;

    // major opcodes
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_TRAP   = 7'b1101011;

    // funct3 codes
    localparam logic [2:0] F3_ADD   = 3'b000;
    localparam logic [2:0] F3_SLL   = 3'b001;
    localparam logic [2:0] F3_WORD  = 3'b010;
    localparam logic [2:0] F3_SLTU  = 3'b011;
    localparam logic [2:0] F3_SR    = 3'b101;
    localparam logic [2:0] F3_BEQ   = 3'b000;
    localparam logic [2:0] F3_BNE   = 3'b001;
    localparam logic [2:0] F3_BLT   = 3'b100;
    localparam logic [2:0] F3_BGE   = 3'b101;
    localparam logic [2:0] F3_BLTU  = 3'b110;
    localparam logic [2:0] F3_BGEU  = 3'b111;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    typedef struct packed {
        logic [KIND_W-1:0]        instr_kind;
        logic                     is_invalid;
        logic [FMT_W-1:0]         format_kind;
        logic [REG_W-1:0]         src1_index;
        logic [REG_W-1:0]         src2_index;
        logic [REG_W-1:0]         dest_index;
        logic signed [WORD_W-1:0] immediate;
        logic                     writes_register;
    } t_dec_result;

endpackage

@@ hw/rtl/rvdec_ifs.sv @@
// Valid/ready channel interfaces for the instruction and decode result beats.
interface rvdec_instr_if;
    logic                           valid;
    logic                           ready;
    logic [rvdec_pkg::WORD_W-1:0]   instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvdec_result_if;
    logic                               valid;
    logic                               ready;
    logic [rvdec_pkg::KIND_W-1:0]       instr_kind;
    logic                               is_invalid;
    logic [rvdec_pkg::FMT_W-1:0]        format_kind;
    logic [rvdec_pkg::REG_W-1:0]        src1_index;
    logic [rvdec_pkg::REG_W-1:0]        src2_index;
    logic [rvdec_pkg::REG_W-1:0]        dest_index;
    logic signed [rvdec_pkg::WORD_W-1:0] immediate;
    logic                               writes_register;

    modport source (output valid, output instr_kind, output is_invalid, output format_kind,
                    output src1_index, output src2_index, output dest_index,
                    output immediate, output writes_register, input ready);
    modport sink   (input valid, input instr_kind, input is_invalid, input format_kind,
                    input src1_index, input src2_index, input dest_index,
                    input immediate, input writes_register, output ready);
endinterface

@@ hw/rtl/rvdec_decode.sv @@
// Combinational decode of one instruction word into kind, format, indices and immediate.
module rvdec_decode (
    input  logic [rvdec_pkg::WORD_W-1:0] i_word,
    output rvdec_pkg::t_dec_result       o_result
);

    logic [6:0]                     op;
    logic [2:0]                     f3;
    logic [6:0]                     f7;
    logic [rvdec_pkg::KIND_W-1:0]   kind;
    logic [rvdec_pkg::FMT_W-1:0]    fmt;
    logic [rvdec_pkg::REG_W-1:0]    s1;
    logic [rvdec_pkg::REG_W-1:0]    s2;
    logic [rvdec_pkg::REG_W-1:0]    d;
    logic [rvdec_pkg::WORD_W-1:0]   imm;

    assign op = i_word[6:0];
    assign f3 = i_word[14:12];
    assign f7 = i_word[31:25];

    // pattern match: first match within each opcode group
    always_comb begin
        kind = rvdec_pkg::K_INV;
        fmt  = rvdec_pkg::F_NONE;
        unique case (op)
            rvdec_pkg::OP_LOAD: begin
                fmt = rvdec_pkg::F_I;
                if (f3 == rvdec_pkg::F3_WORD) kind = rvdec_pkg::K_LW;
            end
            rvdec_pkg::OP_STORE: begin
                fmt = rvdec_pkg::F_S;
                if (f3 == rvdec_pkg::F3_WORD) kind = rvdec_pkg::K_SW;
            end
            rvdec_pkg::OP_LUI: begin
                fmt  = rvdec_pkg::F_U;
                kind = rvdec_pkg::K_LUI;
            end
            rvdec_pkg::OP_AUIPC: begin
                fmt  = rvdec_pkg::F_U;
                kind = rvdec_pkg::K_AUIPC;
            end
            rvdec_pkg::OP_REG: begin
                fmt = rvdec_pkg::F_R;
                if (f3 == rvdec_pkg::F3_ADD) begin
                    if (f7 == rvdec_pkg::F7_BASE)     kind = rvdec_pkg::K_ADD;
                    else if (f7 == rvdec_pkg::F7_ALT) kind = rvdec_pkg::K_SUB;
                end else if (f3 == rvdec_pkg::F3_SR) begin
                    if (f7 == rvdec_pkg::F7_BASE)     kind = rvdec_pkg::K_SRL;
                    else if (f7 == rvdec_pkg::F7_ALT) kind = rvdec_pkg::K_SRA;
                end else if (f3 == rvdec_pkg::F3_SLL) begin
                    kind = rvdec_pkg::K_SLL;   // funct7 not checked
                end
            end
            rvdec_pkg::OP_IMM: begin
                fmt = rvdec_pkg::F_I;
                if (f3 == rvdec_pkg::F3_ADD) begin
                    kind = rvdec_pkg::K_ADDI;
                end else if (f3 == rvdec_pkg::F3_SR) begin
                    if (f7 == rvdec_pkg::F7_BASE)     kind = rvdec_pkg::K_SRLI;
                    else if (f7 == rvdec_pkg::F7_ALT) kind = rvdec_pkg::K_SRAI;
                end else if (f3 == rvdec_pkg::F3_SLL) begin
                    kind = rvdec_pkg::K_SLLI;  // funct7 not checked
                end else if (f3 == rvdec_pkg::F3_SLTU) begin
                    kind = rvdec_pkg::K_SLTIU;
                end
            end
            rvdec_pkg::OP_JALR: begin
                fmt = rvdec_pkg::F_I;
                if (f3 == rvdec_pkg::F3_ADD) kind = rvdec_pkg::K_JALR;
            end
            rvdec_pkg::OP_BRANCH: begin
                fmt = rvdec_pkg::F_B;
                unique case (f3)
                    rvdec_pkg::F3_BEQ:  kind = rvdec_pkg::K_BEQ;
                    rvdec_pkg::F3_BNE:  kind = rvdec_pkg::K_BNE;
                    rvdec_pkg::F3_BLT:  kind = rvdec_pkg::K_BLT;
                    rvdec_pkg::F3_BGE:  kind = rvdec_pkg::K_BGE;
                    rvdec_pkg::F3_BLTU: kind = rvdec_pkg::K_BLTU;
                    rvdec_pkg::F3_BGEU: kind = rvdec_pkg::K_BGEU;
                    default:            kind = rvdec_pkg::K_INV;
                endcase
            end
            rvdec_pkg::OP_JAL:  kind = rvdec_pkg::K_JAL;
            rvdec_pkg::OP_TRAP: kind = rvdec_pkg::K_TRAP;
            default: ;
        endcase
    end

    // operand fields; jal keeps format "none" but still carries rd and its immediate
    always_comb begin
        s1  = '0;
        s2  = '0;
        d   = '0;
        imm = '0;
        if (kind == rvdec_pkg::K_INV || kind == rvdec_pkg::K_TRAP) begin
            s1 = '0;
        end else if (kind == rvdec_pkg::K_JAL) begin
            d   = i_word[11:7];
            imm = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                   i_word[30:21], 1'b0};
        end else begin
            unique case (fmt)
                rvdec_pkg::F_I: begin
                    s1  = i_word[19:15];
                    d   = i_word[11:7];
                    imm = {{20{i_word[31]}}, i_word[31:20]};
                end
                rvdec_pkg::F_R: begin
                    s1 = i_word[19:15];
                    s2 = i_word[24:20];
                    d  = i_word[11:7];
                end
                rvdec_pkg::F_S: begin
                    s1  = i_word[19:15];
                    s2  = i_word[24:20];
                    imm = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
                end
                rvdec_pkg::F_B: begin
                    s1  = i_word[19:15];
                    s2  = i_word[24:20];
                    imm = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                           i_word[11:8], 1'b0};
                end
                default: begin
                    d   = i_word[11:7];
                    imm = {i_word[31:12], 12'b0};
                end
            endcase
        end
    end

    always_comb begin
        o_result.instr_kind      = kind;
        o_result.is_invalid      = (kind == rvdec_pkg::K_INV);
        o_result.format_kind     = (kind == rvdec_pkg::K_INV || kind == rvdec_pkg::K_TRAP)
                                   ? rvdec_pkg::F_NONE : fmt;
        o_result.src1_index      = s1;
        o_result.src2_index      = s2;
        o_result.dest_index      = d;
        o_result.immediate       = imm;
        o_result.writes_register = (d != '0);
    end

endmodule

@@ hw/rtl/rv32i_subset_instruction_decoder_core.sv @@
// Top level: input register, decode logic and result register of the RV32I subset decoder.
//
//   channel   dir  beat payload
//   i_instr   in   instr_word (32 bits)
//   o_result  out  instr_kind, is_invalid, format_kind, src1/src2/dest_index,
//                  immediate, writes_register
//
// One beat in and one beat out per cycle when neither side stalls.
// The instruction register feeds the decode logic, whose output loads the result register.
// i_rst_n (synchronous, active low) empties both stages.
// A stalled result holds in its register; the instruction stage still takes a beat
// whenever it is empty or moves forward in the same cycle.
module rv32i_subset_instruction_decoder_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rvdec_instr_if.sink           i_instr,
    rvdec_result_if.source        o_result
);

    logic                           r_s1_valid;
    logic [rvdec_pkg::WORD_W-1:0]   r_s1_word;
    logic                           r_out_valid;
    rvdec_pkg::t_dec_result         r_out;
    rvdec_pkg::t_dec_result         n_out;
    logic                           s1_ready;
    logic                           s2_ready;

    assign s2_ready = !r_out_valid || o_result.ready;
    assign s1_ready = !r_s1_valid || s2_ready;

    rvdec_decode u_decode (
        .i_word   (r_s1_word),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) r_s1_valid  <= i_instr.valid;
            if (s2_ready) r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_instr.valid) r_s1_word <= i_instr.instr_word;
        if (s2_ready && r_s1_valid)    r_out     <= n_out;
    end

    assign i_instr.ready            = s1_ready;
    assign o_result.valid           = r_out_valid;
    assign o_result.instr_kind      = r_out.instr_kind;
    assign o_result.is_invalid      = r_out.is_invalid;
    assign o_result.format_kind     = r_out.format_kind;
    assign o_result.src1_index      = r_out.src1_index;
    assign o_result.src2_index      = r_out.src2_index;
    assign o_result.dest_index      = r_out.dest_index;
    assign o_result.immediate       = r_out.immediate;
    assign o_result.writes_register = r_out.writes_register;

`ifndef NO_ASSERTIONS
    // a held instruction beat is never dropped while the result stage is blocked
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_ready) |=> r_s1_valid)
        else $error("instruction beat lost while result stage stalled");

    a_invalid_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.is_invalid == (r_out.instr_kind == rvdec_pkg::K_INV)))
        else $error("is_invalid disagrees with instr_kind");

    a_no_write_sb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.format_kind == rvdec_pkg::F_S ||
                         r_out.format_kind == rvdec_pkg::F_B)) |-> !r_out.writes_register)
        else $error("store or branch flagged as register write");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.instr_kind == rvdec_pkg::K_INV ||
                         r_out.instr_kind == rvdec_pkg::K_TRAP))
        |-> (r_out.immediate == '0 && r_out.dest_index == '0 &&
             r_out.format_kind == rvdec_pkg::F_NONE))
        else $error("invalid or trap result carries operand fields");

    a_write_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.writes_register == (r_out.dest_index != '0)))
        else $error("writes_register disagrees with dest_index");
`endif

endmodule

@@ bench/decode_checker.sv @@
// Decode checker: watches both channels, predicts each result beat and compares it.
module decode_checker
    import rvdec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rvdec_instr_if    i_instr,
    rvdec_result_if   i_result,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_results,
    output int        o_kinds_hit,
    output int        o_input_stalls
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_REPORTS = 10;

    t_dec_result decoded_q[$];
    bit          kind_seen[32];
    int          reported;

    // Expected decode of one instruction word.
    function automatic t_dec_result decode_word(input logic [WORD_W-1:0] w);
        logic [6:0]        opc;
        logic [2:0]        f3;
        logic [6:0]        f7;
        logic [KIND_W-1:0] kind;
        logic [FMT_W-1:0]  fmt;
        t_dec_result       r;
        opc  = w[6:0];
        f3   = w[14:12];
        f7   = w[31:25];
        kind = K_INV;
        fmt  = F_NONE;
        r    = '0;
        case (opc)
            OP_LOAD: begin
                fmt = F_I;
                if (f3 == F3_WORD) kind = K_LW;
            end
            OP_STORE: begin
                fmt = F_S;
                if (f3 == F3_WORD) kind = K_SW;
            end
            OP_LUI: begin
                fmt  = F_U;
                kind = K_LUI;
            end
            OP_AUIPC: begin
                fmt  = F_U;
                kind = K_AUIPC;
            end
            OP_REG: begin
                fmt = F_R;
                if (f3 == F3_ADD)
                    kind = (f7 == F7_BASE) ? K_ADD : (f7 == F7_ALT) ? K_SUB : K_INV;
                else if (f3 == F3_SR)
                    kind = (f7 == F7_BASE) ? K_SRL : (f7 == F7_ALT) ? K_SRA : K_INV;
                else if (f3 == F3_SLL)
                    kind = K_SLL;   // funct7 ignored
            end
            OP_IMM: begin
                fmt = F_I;
                if (f3 == F3_ADD)
                    kind = K_ADDI;
                else if (f3 == F3_SR)
                    kind = (f7 == F7_BASE) ? K_SRLI : (f7 == F7_ALT) ? K_SRAI : K_INV;
                else if (f3 == F3_SLL)
                    kind = K_SLLI;  // funct7 ignored
                else if (f3 == F3_SLTU)
                    kind = K_SLTIU;
            end
            OP_JALR: begin
                fmt = F_I;
                if (f3 == F3_ADD) kind = K_JALR;
            end
            OP_BRANCH: begin
                fmt = F_B;
                case (f3)
                    F3_BEQ:  kind = K_BEQ;
                    F3_BNE:  kind = K_BNE;
                    F3_BLT:  kind = K_BLT;
                    F3_BGE:  kind = K_BGE;
                    F3_BLTU: kind = K_BLTU;
                    F3_BGEU: kind = K_BGEU;
                    default: kind = K_INV;
                endcase
            end
            OP_JAL:  kind = K_JAL;
            OP_TRAP: kind = K_TRAP;
            default: ;
        endcase

        r.instr_kind  = kind;
        r.is_invalid  = (kind == K_INV);
        r.format_kind = F_NONE;
        if (kind == K_JAL) begin
            // jal reports no format but carries rd and the J immediate
            r.dest_index = w[11:7];
            r.immediate  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        end else if (kind != K_INV && kind != K_TRAP) begin
            r.format_kind = fmt;
            case (fmt)
                F_I: begin
                    r.src1_index = w[19:15];
                    r.dest_index = w[11:7];
                    r.immediate  = {{20{w[31]}}, w[31:20]};
                end
                F_R: begin
                    r.src1_index = w[19:15];
                    r.src2_index = w[24:20];
                    r.dest_index = w[11:7];
                end
                F_S: begin
                    r.src1_index = w[19:15];
                    r.src2_index = w[24:20];
                    r.immediate  = {{20{w[31]}}, w[31:25], w[11:7]};
                end
                F_B: begin
                    r.src1_index = w[19:15];
                    r.src2_index = w[24:20];
                    r.immediate  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                end
                default: begin
                    r.dest_index = w[11:7];
                    r.immediate  = {w[31:12], 12'b0};
                end
            endcase
        end
        r.writes_register = (r.dest_index != '0);
        return r;
    endfunction

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results      = 0;
        o_kinds_hit    = 0;
        o_input_stalls = 0;
        reported       = 0;
    end

    always @(posedge i_clk) begin : watch
        t_dec_result got;
        t_dec_result want;
        string       bad;
        if (i_rst_n) begin
            if (i_instr.valid && !i_instr.ready)
                o_input_stalls++;

            // pop before push so a stray result never consumes this cycle's beat
            if (i_result.valid && i_result.ready) begin
                got.instr_kind      = i_result.instr_kind;
                got.is_invalid      = i_result.is_invalid;
                got.format_kind     = i_result.format_kind;
                got.src1_index      = i_result.src1_index;
                got.src2_index      = i_result.src2_index;
                got.dest_index      = i_result.dest_index;
                got.immediate       = i_result.immediate;
                got.writes_register = i_result.writes_register;
                o_results++;
                if (decoded_q.size() == 0) begin
                    o_fail_count++;
                    if (reported < MAX_REPORTS) begin
                        reported++;
                        $display("%0t: result beat with nothing expected, kind %0d",
                                 $realtime, got.instr_kind);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (!kind_seen[want.instr_kind]) begin
                        kind_seen[want.instr_kind] = 1'b1;
                        o_kinds_hit++;
                    end
                    bad = "";
                    if (got.instr_kind      !== want.instr_kind)      bad = {bad, " kind"};
                    if (got.is_invalid      !== want.is_invalid)      bad = {bad, " invalid"};
                    if (got.format_kind     !== want.format_kind)     bad = {bad, " format"};
                    if (got.src1_index      !== want.src1_index)      bad = {bad, " rs1"};
                    if (got.src2_index      !== want.src2_index)      bad = {bad, " rs2"};
                    if (got.dest_index      !== want.dest_index)      bad = {bad, " rd"};
                    if (got.immediate       !== want.immediate)       bad = {bad, " imm"};
                    if (got.writes_register !== want.writes_register) bad = {bad, " wr"};
                    if (bad != "") begin
                        o_fail_count++;
                        if (reported < MAX_REPORTS) begin
                            reported++;
                            $display("%0t: mismatch in%s", $realtime, bad);
                            $display("  exp kind %0d inv %0b fmt %0d rs1 %0d rs2 %0d rd %0d imm %h wr %0b",
                                     want.instr_kind, want.is_invalid, want.format_kind,
                                     want.src1_index, want.src2_index, want.dest_index,
                                     want.immediate, want.writes_register);
                            $display("  got kind %0d inv %0b fmt %0d rs1 %0d rs2 %0d rd %0d imm %h wr %0b",
                                     got.instr_kind, got.is_invalid, got.format_kind,
                                     got.src1_index, got.src2_index, got.dest_index,
                                     got.immediate, got.writes_register);
                        end
                    end
                end
            end

            if (i_instr.valid && i_instr.ready)
                decoded_q.push_back(decode_word(i_instr.instr_word));

            o_pending = decoded_q.size();
        end
    end

endmodule

@@ bench/testbench.sv @@
// Top of the decoder bench: clock, reset, instruction and back-pressure stimulus, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rvdec_pkg::*;

    localparam int RANDOM_PER_PHASE = 410;
    localparam int HOLD_CYCLES      = 80;
    localparam int DRAIN_LIMIT      = 2000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int   src_idle_pct = 33;
    int   snk_idle_pct = 60;
    bit   hold_req     = 1'b0;

    int   fail_count;
    int   pending;
    int   results;
    int   kinds_hit;
    int   input_stalls;

    rvdec_instr_if  instr_ch ();
    rvdec_result_if result_ch ();

    rv32i_subset_instruction_decoder_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_ch),
        .o_result (result_ch)
    );

    decode_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_instr        (instr_ch),
        .i_result       (result_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results      (results),
        .o_kinds_hit    (kinds_hit),
        .o_input_stalls (input_stalls)
    );

    always #4 i_clk = ~i_clk;

    // Mostly well-formed words with random fields, some pure noise.
    function automatic logic [WORD_W-1:0] gen_word();
        logic [WORD_W-1:0] w;
        w = $urandom();
        if ($urandom_range(0, 9) == 0)
            return w;
        case ($urandom_range(0, 9))
            0:       w[6:0] = OP_LOAD;
            1:       w[6:0] = OP_STORE;
            2:       w[6:0] = OP_LUI;
            3:       w[6:0] = OP_AUIPC;
            4:       w[6:0] = OP_REG;
            5:       w[6:0] = OP_IMM;
            6:       w[6:0] = OP_JALR;
            7:       w[6:0] = OP_BRANCH;
            8:       w[6:0] = OP_JAL;
            default: w[6:0] = OP_TRAP;
        endcase
        if ($urandom_range(0, 3) != 0) begin
            case (w[6:0])
                OP_LOAD, OP_STORE: w[14:12] = F3_WORD;
                OP_JALR:           w[14:12] = F3_ADD;
                OP_REG: begin
                    case ($urandom_range(0, 2))
                        0:       w[14:12] = F3_ADD;
                        1:       w[14:12] = F3_SLL;
                        default: w[14:12] = F3_SR;
                    endcase
                end
                OP_IMM: begin
                    case ($urandom_range(0, 3))
                        0:       w[14:12] = F3_ADD;
                        1:       w[14:12] = F3_SLL;
                        2:       w[14:12] = F3_SLTU;
                        default: w[14:12] = F3_SR;
                    endcase
                end
                OP_BRANCH: if (w[14:13] == 2'b01) w[14] = 1'b1;
                default: ;
            endcase
            if ((w[6:0] == OP_REG && w[14:12] != F3_SLL) ||
                (w[6:0] == OP_IMM && w[14:12] == F3_SR))
                w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
        end
        if ($urandom_range(0, 9) == 0)
            w[11:7] = '0;
        return w;
    endfunction

    // One instruction beat, with random idle cycles in front of it.
    task automatic send_word(input logic [WORD_W-1:0] w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            instr_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        instr_ch.valid      <= 1'b1;
        instr_ch.instr_word <= w;
        @(posedge i_clk);
        while (!instr_ch.ready) @(posedge i_clk);
    endtask

    // Result side: random stalls, or a long hold-off on request.
    initial begin : sink_side
        int held;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    initial begin : source_side
        logic [WORD_W-1:0] directed[$];
        int                waited;
        int                n;
        instr_ch.valid      = 1'b0;
        instr_ch.instr_word = '0;

        directed.push_back(32'h0000_0000);
        directed.push_back(32'hFFFF_FFFF);
        directed.push_back({12'hFFF, 5'd31, F3_WORD, 5'd0, OP_LOAD});
        directed.push_back({12'h7FF, 5'd0, F3_ADD, 5'd31, OP_LOAD});
        directed.push_back({7'h7F, 5'd31, 5'd31, F3_WORD, 5'd31, OP_STORE});
        directed.push_back({7'h3F, 5'd1, 5'd2, F3_SLL, 5'd0, OP_STORE});
        directed.push_back({20'hFFFFF, 5'd31, OP_LUI});
        directed.push_back({20'h80000, 5'd0, OP_AUIPC});
        directed.push_back({F7_BASE, 5'd31, 5'd31, F3_ADD, 5'd31, OP_REG});
        directed.push_back({F7_ALT, 5'd1, 5'd2, F3_ADD, 5'd3, OP_REG});
        // shift-left ignores funct7
        directed.push_back({7'h7F, 5'd4, 5'd5, F3_SLL, 5'd6, OP_REG});
        directed.push_back({F7_BASE, 5'd7, 5'd8, F3_SR, 5'd9, OP_REG});
        directed.push_back({F7_ALT, 5'd10, 5'd11, F3_SR, 5'd12, OP_REG});
        directed.push_back({7'h01, 5'd13, 5'd14, F3_SR, 5'd15, OP_REG});
        directed.push_back({12'h800, 5'd31, F3_ADD, 5'd31, OP_IMM});
        directed.push_back({7'h55, 5'd7, 5'd8, F3_SLL, 5'd9, OP_IMM});
        directed.push_back({F7_BASE, 5'd31, 5'd16, F3_SR, 5'd17, OP_IMM});
        directed.push_back({F7_ALT, 5'd18, 5'd19, F3_SR, 5'd20, OP_IMM});
        directed.push_back({7'h60, 5'd21, 5'd22, F3_SR, 5'd23, OP_IMM});
        directed.push_back({12'h7FF, 5'd24, F3_SLTU, 5'd25, OP_IMM});
        directed.push_back({12'hFFF, 5'd1, F3_ADD, 5'd0, OP_JALR});
        directed.push_back({12'h001, 5'd1, F3_SLL, 5'd1, OP_JALR});
        directed.push_back({20'hFFFFF, 5'd31, OP_JAL});
        directed.push_back({20'h80000, 5'd0, OP_JAL});
        directed.push_back({7'h7F, 5'd31, 5'd31, F3_BEQ, 5'd31, OP_BRANCH});
        directed.push_back({7'h00, 5'd0, 5'd1, F3_BLTU, 5'd1, OP_BRANCH});
        directed.push_back({7'h40, 5'd2, 5'd3, F3_WORD, 5'd4, OP_BRANCH});
        directed.push_back({25'h1FF_FFFF, OP_TRAP});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_word(directed[k]);

        for (n = 0; n < RANDOM_PER_PHASE; n++) send_word(gen_word());

        src_idle_pct = 60;
        snk_idle_pct = 33;
        for (n = 0; n < RANDOM_PER_PHASE; n++) send_word(gen_word());

        // full rate; the result side backs off once so the pipeline fills
        src_idle_pct = 0;
        snk_idle_pct = 0;
        for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == 100) hold_req = 1'b1;
            send_word(gen_word());
        end
        instr_ch.valid <= 1'b0;

        waited = 0;
        @(negedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);

        $display("summary: %0d decode beats checked, %0d of 24 result kinds seen",
                 results, kinds_hit);
        $display("summary: input held back on %0d cycles, %0d results missing, %0d failures",
                 input_stalls, pending, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/rvdec_pkg.sv
hw/rtl/rvdec_ifs.sv
hw/rtl/rvdec_decode.sv
hw/rtl/rv32i_subset_instruction_decoder_core.sv
bench/decode_checker.sv
bench/testbench.sv
